// ----- hdl/pdc_pkg.sv -----
// Package for the PD drive-distance controller.
// Holds shared constants, config register indexes and a helper type.
// No dependencies.
package pdc_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam logic [31:0] DIST_SCALE_Q32 = 32'd88668533;

    localparam logic [2:0] REG_TARGET  = 3'd0;
    localparam logic [2:0] REG_MAXSPD  = 3'd1;
    localparam logic [2:0] REG_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_HDGTGT  = 3'd3;
    localparam logic [2:0] REG_GAINP   = 3'd4;
    localparam logic [2:0] REG_GAIND   = 3'd5;
    localparam logic [2:0] REG_GAINH   = 3'd6;

    localparam logic [1:0] FIN_RUN     = 2'd0;
    localparam logic [1:0] FIN_SETTLED = 2'd1;
    localparam logic [1:0] FIN_TIMEOUT = 2'd2;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  sh;
    } t_mul_req;

endpackage

// ----- hdl/pd_drive_distance_controller.sv -----
// PD drive-distance controller. A request (control tick) is accepted only in
// idle; the controller works through its sequencer states, then offers the
// result until it is taken before it accepts the next request. A tick with a
// zero time step skips the derivative quotient. A tick on a stopped or
// timed-out move computes only the travelled distance. Each of the seven
// products runs on one shared 32x32 multiplier in steps: load, four partial
// products and round. The derivative quotient runs on a one-bit-per-cycle
// divider. The heading wrap is a compare-subtract loop. o_ready is low while a
// tick is processed or its result waits to be taken.
// Depends on pdc_pkg, pdc_mul, pdc_div.
module pd_drive_distance_controller
    import pdc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_start_req,
    input  logic signed [31:0] i_left_position,
    input  logic signed [31:0] i_right_position,
    input  logic signed [31:0] i_heading,
    input  logic [31:0]        i_time_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [19:0] o_left_drive,
    output logic signed [19:0] o_right_drive,
    output logic signed [31:0] o_travelled,
    output logic [1:0]         o_status
);

    localparam logic [5:0] SH_F = 6'(FRAC_BITS);
    localparam logic signed [63:0] HUNDRED = 64'sd100 <<< FRAC_BITS;
    localparam logic signed [63:0] OFFSET  = 64'sd900 <<< FRAC_BITS;
    localparam logic [63:0] MOD_TOP = 64'd360 << 24;
    localparam logic [4:0] MOD_LAST = 5'(24 - FRAC_BITS);
    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
    localparam logic signed [63:0] S32MIN = -64'sd2147483648;
    localparam logic signed [63:0] S32MAX = 64'sd2147483647;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TRAV  = 4'd1;
    localparam logic [3:0] ST_CHECK = 4'd2;
    localparam logic [3:0] ST_PROP  = 4'd3;
    localparam logic [3:0] ST_DNUM  = 4'd4;
    localparam logic [3:0] ST_DDIV  = 4'd5;
    localparam logic [3:0] ST_MOD   = 4'd6;
    localparam logic [3:0] ST_HG    = 4'd7;
    localparam logic [3:0] ST_TURN  = 4'd8;
    localparam logic [3:0] ST_LV    = 4'd9;
    localparam logic [3:0] ST_RV    = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;
    localparam logic [3:0] ST_HMOD  = 4'd13;

    logic signed [31:0] r_target, r_hdg_tgt;
    logic [14:0] r_max_speed;
    logic [19:0] r_timeout;
    logic [30:0] r_gain_p, r_gain_d, r_gain_h;

    logic signed [63:0] r_start_avg, r_last_err;
    logic [31:0] r_start_time, r_last_time, r_settle;
    logic r_in_bounds;
    logic [1:0] r_fin;

    logic [3:0] r_state;
    logic r_wait;
    logic signed [63:0] r_avg, r_hdg, r_err, r_power, r_herr, r_hg, r_turn;
    logic [31:0] r_now;
    logic signed [19:0] r_ldrv, r_rdrv;
    logic signed [31:0] r_trav;
    logic r_dneg;
    logic [63:0] r_hmag, r_msub;
    logic r_hneg;
    logic [4:0] r_mk;

    t_mul_req w_mreq;
    logic w_mdone, w_ddone, w_dstart;
    logic signed [63:0] w_mres;
    logic [63:0] w_quo, w_dnum;
    logic signed [32:0] w_sum;
    logic signed [63:0] w_avg, w_lim, w_pw, w_rq, w_errs, w_a, w_b;
    logic signed [63:0] w_travs, w_hdiff;
    logic [31:0] w_dt;
    logic [63:0] w_rqm, w_hsub;

    pdc_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_mreq),
        .o_done(w_mdone), .o_res(w_mres)
    );

    pdc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dt), .o_done(w_ddone), .o_quo(w_quo)
    );

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v < S32MIN) return S32MIN;
        if (v > S32MAX) return S32MAX;
        return v;
    endfunction

    function automatic logic signed [19:0] drive(input logic signed [63:0] v);
        logic signed [63:0] t;
        logic signed [63:0] q;
        t = v;
        if (v > HUNDRED) t = v + OFFSET;
        else if (v < HUNDRED) t = v - OFFSET;
        q = t[63] ? -((-t) >>> FRAC_BITS) : (t >>> FRAC_BITS);
        if (q < -64'sd524288) return -20'sd524288;
        if (q > 64'sd524287) return 20'sd524287;
        return q[19:0];
    endfunction

    assign w_sum = {i_left_position[31], i_left_position}
                 + {i_right_position[31], i_right_position};
    assign w_avg = 64'(w_sum >>> 1);
    assign w_lim = $signed({49'd0, r_max_speed}) <<< FRAC_BITS;
    assign w_dt  = r_now - r_last_time;
    assign w_dnum = w_mres[63] ? 64'd0 - w_mres : w_mres;
    assign w_dstart = (r_state == ST_DNUM) && w_mdone && !r_wait;
    assign w_rqm = (w_quo + HALF) >> FRAC_BITS;
    assign w_rq  = r_dneg ? -$signed(w_rqm) : $signed(w_rqm);
    assign w_pw  = r_power + w_rq;
    assign w_errs = sat32(64'(r_target) - 64'(r_trav));
    assign w_travs = sat32(w_mres);
    assign w_hdiff = 64'(r_hdg_tgt) - r_hdg;
    assign w_hsub = (r_hmag >= r_msub) ? r_hmag - r_msub : r_hmag;
    assign w_a = -r_power - r_turn;
    assign w_b = -r_power + r_turn;

    always_comb begin
        w_mreq = '0;
        if (r_wait) begin
            w_mreq.start = 1'b1;
            unique case (r_state)
                ST_TRAV: begin
                    w_mreq.a = r_avg - r_start_avg;
                    w_mreq.b = {32'd0, DIST_SCALE_Q32};
                    w_mreq.sh = 6'd32;
                end
                ST_PROP: begin
                    w_mreq.a = r_err; w_mreq.b = {33'd0, r_gain_p}; w_mreq.sh = SH_F;
                end
                ST_DNUM: begin
                    w_mreq.a = r_err - r_last_err; w_mreq.b = {33'd0, r_gain_d};
                end
                ST_HG: begin
                    w_mreq.a = r_herr; w_mreq.b = {33'd0, r_gain_h}; w_mreq.sh = SH_F;
                end
                ST_TURN: begin
                    w_mreq.a = r_hg; w_mreq.b = r_power; w_mreq.sh = SH_F;
                end
                ST_LV: begin w_mreq.a = w_a; w_mreq.b = 64'sd55; end
                ST_RV: begin w_mreq.a = w_b; w_mreq.b = 64'sd55; end
                default: w_mreq.start = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0; r_max_speed <= 15'd150; r_timeout <= '0;
            r_hdg_tgt <= '0; r_gain_p <= 31'd983040; r_gain_d <= 31'd13107200;
            r_gain_h <= 31'd3277;
            r_start_avg <= '0; r_last_err <= '0; r_start_time <= '0;
            r_last_time <= '0; r_settle <= '0; r_in_bounds <= 1'b0;
            r_fin <= FIN_RUN; r_state <= ST_IDLE; r_wait <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_TARGET:  r_target    <= i_cfg_data;
                    REG_MAXSPD:  r_max_speed <= i_cfg_data[14:0];
                    REG_TIMEOUT: r_timeout   <= i_cfg_data[19:0];
                    REG_HDGTGT:  r_hdg_tgt   <= i_cfg_data;
                    REG_GAINP:   r_gain_p    <= i_cfg_data[30:0];
                    REG_GAIND:   r_gain_d    <= i_cfg_data[30:0];
                    REG_GAINH:   r_gain_h    <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            r_wait <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_avg <= w_avg; r_now <= i_time_ms;
                    r_hdg <= 64'(i_heading);
                    r_ldrv <= '0; r_rdrv <= '0;
                    if (i_start_req) begin
                        r_start_avg <= w_avg; r_start_time <= i_time_ms;
                        r_last_time <= i_time_ms; r_last_err <= 64'(r_target);
                        r_in_bounds <= 1'b0; r_settle <= '0; r_fin <= FIN_RUN;
                    end
                    r_state <= ST_TRAV; r_wait <= 1'b1;
                end
                ST_TRAV: if (w_mdone) begin
                    r_trav <= w_travs[31:0];
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (r_fin == FIN_RUN && (r_now - r_start_time) >= {12'd0, r_timeout})
                    begin
                        r_fin <= FIN_TIMEOUT; r_state <= ST_OUT;
                    end else if (r_fin != FIN_RUN) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_err <= w_errs; r_state <= ST_PROP; r_wait <= 1'b1;
                    end
                end
                ST_PROP: if (w_mdone) begin
                    r_power <= w_mres;
                    if (w_dt != 32'd0) begin
                        r_state <= ST_DNUM; r_wait <= 1'b1;
                    end else r_state <= ST_MOD;
                end
                ST_DNUM: if (w_mdone && !r_wait) begin
                    r_dneg <= w_mres[63]; r_state <= ST_DDIV;
                end
                ST_DDIV: if (w_ddone) begin
                    r_power <= w_pw; r_state <= ST_MOD;
                end
                ST_MOD: begin
                    if (r_power > w_lim) r_power <= w_lim;
                    else if (r_power < -w_lim) r_power <= -w_lim;
                    r_hmag <= w_hdiff[63] ? 64'd0 - w_hdiff : w_hdiff;
                    r_hneg <= w_hdiff[63];
                    r_msub <= MOD_TOP;
                    r_mk <= MOD_LAST;
                    r_state <= ST_HMOD;
                end
                ST_HMOD: begin
                    if (r_mk == 5'd0) begin
                        r_herr <= r_hneg ? -$signed(w_hsub) : $signed(w_hsub);
                        r_state <= ST_HG; r_wait <= 1'b1;
                    end else begin
                        r_hmag <= w_hsub; r_msub <= r_msub >> 1; r_mk <= r_mk - 5'd1;
                    end
                end
                ST_HG: if (w_mdone) begin
                    r_hg <= w_mres; r_state <= ST_TURN; r_wait <= 1'b1;
                end
                ST_TURN: if (w_mdone) begin
                    r_turn <= w_mres; r_state <= ST_LV; r_wait <= 1'b1;
                end
                ST_LV: if (w_mdone) begin
                    r_ldrv <= drive(w_mres); r_state <= ST_RV; r_wait <= 1'b1;
                end
                ST_RV: if (w_mdone) begin
                    r_rdrv <= drive(w_mres); r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_last_err <= r_err; r_last_time <= r_now;
                    r_in_bounds <= (r_err[63] ? 64'd0 - r_err : r_err) < HALF;
                    if ((r_err[63] ? 64'd0 - r_err : r_err) < HALF) begin
                        if (!r_in_bounds) r_settle <= r_now;
                        if ((r_now - (r_in_bounds ? r_settle : r_now)) > 32'd500) begin
                            r_fin <= FIN_SETTLED; r_ldrv <= '0; r_rdrv <= '0;
                        end
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: if (i_ready) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_left_drive  = r_ldrv;
    assign o_right_drive = r_rdrv;
    assign o_travelled   = r_trav;
    assign o_status      = r_fin;

    ap_out_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_fin != FIN_RUN) |-> (r_ldrv == '0 && r_rdrv == '0))
        else $error("drive while stopped");
    ap_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while result pending");
    ap_fin_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin != 2'd3) else $error("bad finish code");

endmodule

// ----- hdl/pdc_mul.sv -----
// Shared signed multiplier: 64x64 magnitude product by 32x32 partial products,
// one per cycle, then round-half-away shift and saturation at 2^62.
// Depends on pdc_pkg.
module pdc_mul
    import pdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_req           i_req,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    localparam logic [63:0] MAG_LIMIT = 64'h4000_0000_0000_0000;

    logic [63:0]  r_ua, r_ub;
    logic         r_neg;
    logic [5:0]   r_sh;
    logic [2:0]   r_step;
    logic         r_busy;
    logic [127:0] r_acc;
    logic         r_done;
    logic signed [63:0] r_res;

    logic [31:0]  w_x, w_y;
    logic [63:0]  w_pp;
    logic [127:0] w_ppsh;
    logic [127:0] w_rnd;
    logic [127:0] w_sft;
    logic [63:0]  w_mag;

    always_comb begin
        unique case (r_step[1:0])
            2'd0: begin w_x = r_ua[31:0];  w_y = r_ub[31:0];  end
            2'd1: begin w_x = r_ua[31:0];  w_y = r_ub[63:32]; end
            2'd2: begin w_x = r_ua[63:32]; w_y = r_ub[31:0];  end
            default: begin w_x = r_ua[63:32]; w_y = r_ub[63:32]; end
        endcase
        w_pp = {32'd0, w_x} * {32'd0, w_y};
        unique case (r_step[1:0])
            2'd0: w_ppsh = {64'd0, w_pp};
            2'd1, 2'd2: w_ppsh = {32'd0, w_pp, 32'd0};
            default: w_ppsh = {w_pp, 64'd0};
        endcase
        w_rnd = (r_sh == 6'd0) ? 128'd0 : (128'd1 << (r_sh - 6'd1));
        w_sft = (r_acc + w_rnd) >> r_sh;
        w_mag = (w_sft[127:64] != 64'd0 || w_sft[63:0] > MAG_LIMIT) ? MAG_LIMIT
                : w_sft[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_ua   <= i_req.a[63] ? 64'd0 - i_req.a : i_req.a;
                r_ub   <= i_req.b[63] ? 64'd0 - i_req.b : i_req.b;
                r_neg  <= i_req.a[63] ^ i_req.b[63];
                r_sh   <= i_req.sh;
                r_acc  <= 128'd0;
                r_step <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    r_res  <= r_neg ? 64'sd0 - $signed(w_mag) : $signed(w_mag);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_acc  <= r_acc + w_ppsh;
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    ap_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    ap_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= 3'd4) else $error("step overrun");
    ap_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");

endmodule

// ----- hdl/pdc_div.sv -----
// Restoring divider: unsigned 64 / 32, one quotient bit per cycle.
// Depends on pdc_pkg.
module pdc_div
    import pdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);

    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [31:0] r_den;
    logic [32:0] w_sh;

    assign w_sh = {r_rem[31:0], r_quo[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_num;
                r_rem  <= 33'd0;
                r_den  <= i_den;
                r_cnt  <= 7'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    ap_rem_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != 7'd0) |-> (r_rem < {1'b0, r_den}))
        else $error("remainder out of range");
    ap_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");
    ap_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !$rose(r_done) || $past(r_cnt) == 7'd63)
        else $error("early done");

endmodule
